// ===== hdl/best_fit_bin_packer_top_defines.svh =====
// Assertion macros shared by the best-fit bin packer RTL.
// Included by bfp_ctrl, the module that carries concurrent assertions; no other dependencies.
`ifndef BEST_FIT_BIN_PACKER_TOP_DEFINES_SVH
`define BEST_FIT_BIN_PACKER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/bfp_pkg.sv =====
// Shared types and constants for the best-fit bin packer.
// No dependencies; used by bfp_ctrl, the top level and the testbench, not by bfp_layer_mem.
package bfp_pkg;

	// Reset value of the layer capacity register.
	localparam int unsigned CAP_RESET = 50;

	// Register index of bin_capacity on the configuration port.
	localparam logic REG_BIN_CAPACITY = 1'b0;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_PLACED   = 2'd0,
		STATUS_TOO_WIDE = 2'd1,
		STATUS_FULL     = 2'd2
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE
	} fsm_t;

	// Flags that accompany one result from the controller.
	typedef struct packed {
		logic    opened_new;
		status_t status;
	} res_flags_t;

endpackage

// ===== hdl/bfp_layer_mem.sv =====
// Layer table memory: one write port, one read port with registered data.
// Uses no package items; instantiated by the top level.
module bfp_layer_mem #(
	parameter int DEPTH  = 64,
	parameter int AW     = 6,
	parameter int DW     = 30
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port, loaded when rd_en is set.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/bfp_ctrl.sv =====
// Sequencer of the best-fit packer: scans the layer table, picks a layer and writes it back when the box is placed.
// Depends on bfp_pkg and the assertion macros in best_fit_bin_packer_top_defines.svh.
`include "best_fit_bin_packer_top_defines.svh"

module bfp_ctrl #(
	parameter int MAX_LAYERS = 64,
	parameter int DIM_BITS   = 10,
	parameter int IDX_BITS   = 6,
	parameter int CNT_BITS   = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Box input
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DIM_BITS-1:0]   in_width,
	input  logic [DIM_BITS-1:0]   in_height,
	input  logic [DIM_BITS-1:0]   in_length,
	input  logic                  in_last,
	input  logic [DIM_BITS-1:0]   bin_capacity,
	// Layer memory
	output logic                  mem_wr_en,
	output logic [IDX_BITS-1:0]   mem_wr_addr,
	output logic [3*DIM_BITS-1:0] mem_wr_data,
	output logic                  mem_rd_en,
	output logic [IDX_BITS-1:0]   mem_rd_addr,
	input  logic [3*DIM_BITS-1:0] mem_rd_data,
	// Result
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic [IDX_BITS-1:0]   res_index,
	output logic [DIM_BITS-1:0]   res_width_left,
	output logic [DIM_BITS-1:0]   res_length,
	output logic [DIM_BITS-1:0]   res_height,
	output bfp_pkg::res_flags_t   res_flags
);

	localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_LAYERS);

	bfp_pkg::fsm_t state_q, state_next;

	// Box being processed.
	logic [DIM_BITS-1:0] w_q, h_q, l_q;
	logic                last_q;

	// Table occupancy and scan position.
	logic [CNT_BITS-1:0] open_cnt_q, open_cnt_next;
	logic [CNT_BITS-1:0] rd_cnt_q;
	logic                rvalid_s1;
	logic [IDX_BITS-1:0] raddr_s1;

	// Best layer so far.
	logic                found_q;
	logic [IDX_BITS-1:0] best_idx_q;
	logic [DIM_BITS-1:0] best_slack_q, best_len_q, best_hgt_q;

	// Read data fields and fit test.
	logic [DIM_BITS-1:0] rd_rem, rd_len, rd_hgt, rd_slack;
	logic                rd_better;

	logic                accept, too_wide, can_open, do_write;

	assign accept = in_valid && in_ready;

	// Next-state logic.
	always_comb begin
		state_next = state_q;
		case (state_q)
			bfp_pkg::S_IDLE: begin
				if (in_valid) state_next = bfp_pkg::S_SCAN;
			end
			bfp_pkg::S_SCAN: begin
				if (rd_cnt_q >= open_cnt_q) state_next = bfp_pkg::S_DECIDE;
			end
			bfp_pkg::S_DECIDE: begin
				if (res_ready) state_next = bfp_pkg::S_IDLE;
			end
			default: state_next = bfp_pkg::S_IDLE;
		endcase
	end

	// State-dependent outputs.
	always_comb begin
		in_ready  = 1'b0;
		mem_rd_en = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			bfp_pkg::S_IDLE:   in_ready  = 1'b1;
			bfp_pkg::S_SCAN:   mem_rd_en = rd_cnt_q < open_cnt_q;
			bfp_pkg::S_DECIDE: res_valid = 1'b1;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign mem_rd_addr = rd_cnt_q[IDX_BITS-1:0];

	// Unpack the entry from the registered read port and test it against the box.
	assign rd_rem    = mem_rd_data[DIM_BITS-1:0];
	assign rd_len    = mem_rd_data[2*DIM_BITS-1:DIM_BITS];
	assign rd_hgt    = mem_rd_data[3*DIM_BITS-1:2*DIM_BITS];
	assign rd_slack  = rd_rem - w_q;
	assign rd_better = (rd_rem >= w_q) && (!found_q || (rd_slack < best_slack_q));

	// Decision on the chosen layer once the scan is over.
	assign too_wide = w_q > bin_capacity;
	assign can_open = open_cnt_q < MAX_CNT;

	always_comb begin
		res_index            = '0;
		res_width_left       = '0;
		res_length           = '0;
		res_height           = '0;
		res_flags.opened_new = 1'b0;
		res_flags.status     = bfp_pkg::STATUS_PLACED;
		do_write             = 1'b0;
		open_cnt_next        = open_cnt_q;
		if (too_wide) begin
			res_flags.status = bfp_pkg::STATUS_TOO_WIDE;
		end else if (found_q) begin
			do_write       = 1'b1;
			res_index      = best_idx_q;
			res_width_left = best_slack_q;
			res_length     = (l_q > best_len_q) ? l_q : best_len_q;
			res_height     = best_hgt_q;
		end else if (can_open) begin
			do_write             = 1'b1;
			res_index            = open_cnt_q[IDX_BITS-1:0];
			res_width_left       = bin_capacity - w_q;
			res_length           = l_q;
			res_height           = h_q;
			res_flags.opened_new = 1'b1;
			open_cnt_next        = open_cnt_q + CNT_BITS'(1);
		end else begin
			res_flags.status = bfp_pkg::STATUS_FULL;
		end
		if (last_q) begin
			open_cnt_next = '0;
		end
	end

	// Write back the updated or newly opened layer as the result leaves.
	assign mem_wr_en   = (state_q == bfp_pkg::S_DECIDE) && res_ready && do_write;
	assign mem_wr_addr = res_index;
	assign mem_wr_data = {res_height, res_length, res_width_left};

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bfp_pkg::S_IDLE;
			open_cnt_q <= '0;
			rd_cnt_q   <= '0;
			rvalid_s1  <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			state_q   <= state_next;
			rvalid_s1 <= mem_rd_en;
			if (accept) begin
				rd_cnt_q <= '0;
				found_q  <= 1'b0;
			end else begin
				if (mem_rd_en) rd_cnt_q <= rd_cnt_q + CNT_BITS'(1);
				if (rvalid_s1 && rd_better) found_q <= 1'b1;
			end
			if ((state_q == bfp_pkg::S_DECIDE) && res_ready) begin
				open_cnt_q <= open_cnt_next;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			w_q    <= in_width;
			h_q    <= in_height;
			l_q    <= in_length;
			last_q <= in_last;
		end
		raddr_s1 <= mem_rd_addr;
		if (rvalid_s1 && rd_better) begin
			best_idx_q   <= raddr_s1;
			best_slack_q <= rd_slack;
			best_len_q   <= rd_len;
			best_hgt_q   <= rd_hgt;
		end
	end

	// Checks on the sequencer.
	`BFP_ASSERT_SAME(a_cnt_bound, clk, arst_n, 1'b1, open_cnt_q <= MAX_CNT, "open count beyond table")
	`BFP_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, state_q != bfp_pkg::S_IDLE, "idle after accept")
	`BFP_ASSERT_SAME(a_rdata_in_scan, clk, arst_n, rvalid_s1, state_q == bfp_pkg::S_SCAN, "read data outside scan")
	`BFP_ASSERT_SAME(a_open_placed, clk, arst_n, res_valid && res_flags.opened_new, res_flags.status == bfp_pkg::STATUS_PLACED, "new layer without placement")

endmodule

// ===== hdl/best_fit_bin_packer_top.sv =====
// Top level of the best-fit bin packer: stream ports, APB register and result register.
// Depends on bfp_pkg, bfp_layer_mem and bfp_ctrl.
//
// Channel | Dir | Contents
// s_*     | in  | tdata = box_width, box_height, box_length (low to high); tlast = last_box
// m_*     | out | tdata = layer_index, opened_new, width_left, layer_length, layer_height;
//         |     | tuser = status
// APB     | in  | bin_capacity at byte address 0
//
// A box is accepted in the idle state; the layer memory is then read one entry per cycle
// over the open layers, and the decide state picks the layer and writes it back.
// A result waits in an output register; the next box is accepted meanwhile, and only the
// decide state stalls, while that register is full and not being drained. Reset empties the
// table and sets the capacity to 50; layer memory contents need no clearing.
module best_fit_bin_packer_top #(
	parameter int MAX_LAYERS = 64,
	parameter int DIM_BITS   = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Box stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [((3 * DIM_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	                                        // box_width, box_height, box_length, zero pad
	input  logic                  s_tlast,
	// Result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [(($clog2(MAX_LAYERS) + 1 + 3 * DIM_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	                                        // layer_index, opened_new, width_left,
	                                        // layer_length, layer_height, zero pad
	output logic [1:0]            m_tuser,  // status
	// Configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int IDX_BITS = $clog2(MAX_LAYERS);
	localparam int CNT_BITS = $clog2(MAX_LAYERS + 1);
	localparam int OUT_RAW  = IDX_BITS + 1 + 3 * DIM_BITS;
	localparam int OUT_BITS = ((OUT_RAW + 7) / 8) * 8;

	logic [DIM_BITS-1:0]   cap_q;
	logic                  cfg_wr;

	logic                  mem_wr_en, mem_rd_en;
	logic [IDX_BITS-1:0]   mem_wr_addr, mem_rd_addr;
	logic [3*DIM_BITS-1:0] mem_wr_data, mem_rd_data;

	logic                  res_valid, res_ready;
	logic [IDX_BITS-1:0]   res_index;
	logic [DIM_BITS-1:0]   res_width_left, res_length, res_height;
	bfp_pkg::res_flags_t   res_flags;

	logic                  out_valid_q;
	logic [OUT_RAW-1:0]    out_data_q;
	bfp_pkg::status_t      out_status_q;

	// Configuration register.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == bfp_pkg::REG_BIN_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= DIM_BITS'(bfp_pkg::CAP_RESET);
		end else if (cfg_wr) begin
			cap_q <= pwdata[DIM_BITS-1:0];
		end
	end

	assign prdata = (paddr[2] == bfp_pkg::REG_BIN_CAPACITY) ? 32'(cap_q) : 32'd0;

	// Layer table.
	bfp_layer_mem #(
		.DEPTH (MAX_LAYERS),
		.AW    (IDX_BITS),
		.DW    (3 * DIM_BITS)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// Scan and decision sequencer.
	bfp_ctrl #(
		.MAX_LAYERS (MAX_LAYERS),
		.DIM_BITS   (DIM_BITS),
		.IDX_BITS   (IDX_BITS),
		.CNT_BITS   (CNT_BITS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.in_width       (s_tdata[DIM_BITS-1:0]),
		.in_height      (s_tdata[2*DIM_BITS-1:DIM_BITS]),
		.in_length      (s_tdata[3*DIM_BITS-1:2*DIM_BITS]),
		.in_last        (s_tlast),
		.bin_capacity   (cap_q),
		.mem_wr_en      (mem_wr_en),
		.mem_wr_addr    (mem_wr_addr),
		.mem_wr_data    (mem_wr_data),
		.mem_rd_en      (mem_rd_en),
		.mem_rd_addr    (mem_rd_addr),
		.mem_rd_data    (mem_rd_data),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.res_index      (res_index),
		.res_width_left (res_width_left),
		.res_length     (res_length),
		.res_height     (res_height),
		.res_flags      (res_flags)
	);

	// Output register: takes a result when empty or being drained.
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q   <= {res_height, res_length, res_width_left,
			                 res_flags.opened_new, res_index};
			out_status_q <= res_flags.status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_BITS'(out_data_q);
	assign m_tuser  = out_status_q;

endmodule

// ===== test/best_fit_bin_packer_top_tb.sv =====
// Testbench for best_fit_bin_packer_top. It sends boxes over the stream port, keeps its own
// best-fit layer table, and checks every placement result field by field.
// Depends on bfp_pkg and best_fit_bin_packer_top.
module best_fit_bin_packer_top_tb;

	localparam int LAYERS = 64;
	localparam int DIM_MAX = 1023;
	localparam logic [2:0] ADDR_CAPACITY = {2'b00, bfp_pkg::REG_BIN_CAPACITY} << 2;
	localparam logic [2:0] ADDR_UNMAPPED = 3'd4;
	localparam int DRAIN_LIMIT = 20000;

	typedef struct packed {
		logic       last;
		logic [9:0] length;
		logic [9:0] height;
		logic [9:0] width;
	} box_t;

	typedef struct packed {
		logic [5:0]       layer;
		logic             opened;
		logic [9:0]       room_left;
		logic [9:0]       length;
		logic [9:0]       height;
		bfp_pkg::status_t status;
	} placement_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;  // box_width, box_height, box_length, zero pad
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;       // layer_index, opened_new, width_left, layer_length,
	                            // layer_height, zero pad
	logic [1:0]  m_tuser;       // status
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Shadow of the layer table and the capacity register.
	logic [9:0] layer_room [LAYERS];
	logic [9:0] layer_len [LAYERS];
	logic [9:0] layer_hgt [LAYERS];
	int         layers_open = 0;
	logic [9:0] capacity_cfg = 10'(bfp_pkg::CAP_RESET);

	placement_t placements_due[$];
	int         mismatches = 0;
	bit         idle_on = 1'b1;

	best_fit_bin_packer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Places one box in the shadow table and returns the result the block should give.
	function automatic placement_t place_box(box_t b);
		placement_t p;
		int         best;
		logic [9:0] best_slack;
		p = '0;
		p.status = bfp_pkg::STATUS_PLACED;
		best = -1;
		best_slack = '0;
		if (b.width > capacity_cfg) begin
			p.status = bfp_pkg::STATUS_TOO_WIDE;
		end else begin
			for (int i = 0; i < layers_open; i++) begin
				if (layer_room[i] >= b.width &&
				    (best < 0 || layer_room[i] - b.width < best_slack)) begin
					best = i;
					best_slack = layer_room[i] - b.width;
				end
			end
			if (best >= 0) begin
				layer_room[best] = best_slack;
				if (b.length > layer_len[best])
					layer_len[best] = b.length;
			end else if (layers_open < LAYERS) begin
				best = layers_open;
				layer_room[best] = capacity_cfg - b.width;
				layer_len[best] = b.length;
				layer_hgt[best] = b.height;
				layers_open++;
				p.opened = 1'b1;
			end else begin
				p.status = bfp_pkg::STATUS_FULL;
			end
			if (best >= 0) begin
				p.layer = best[5:0];
				p.room_left = layer_room[best];
				p.length = layer_len[best];
				p.height = layer_hgt[best];
			end
		end
		if (b.last)
			layers_open = 0;
		return p;
	endfunction

	function automatic box_t mk_box(int w, int h, int l, bit last);
		box_t b;
		b.width = w[9:0];
		b.height = h[9:0];
		b.length = l[9:0];
		b.last = last;
		return b;
	endfunction

	// Presents one box and waits for the transaction, then records its expected result.
	task automatic send_box(box_t b);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 23) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, b.length, b.height, b.width};
		s_tlast <= b.last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		placements_due = {placements_due, place_box(b)};
	endtask

	// Drops the stream, waits for every result, then lets the block settle.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		for (int n = 0; n < DRAIN_LIMIT && placements_due.size() != 0; n++)
			@(posedge clk);
		if (placements_due.size() != 0) begin
			$error("%0d results never arrived", placements_due.size());
			mismatches++;
			placements_due.delete();
		end
		repeat (LAYERS + 8) @(posedge clk);
	endtask

	// One APB transfer: setup cycle, then access cycle until pready.
	task automatic apb_transfer(bit wr, logic [2:0] addr, logic [31:0] data,
	                            output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Writes a register while the block is idle and reads the capacity back.
	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		logic [31:0] rd;
		wait_idle();
		apb_transfer(1'b1, addr, data, rd);
		if (addr == ADDR_CAPACITY)
			capacity_cfg = data[9:0];
		apb_transfer(1'b0, ADDR_CAPACITY, '0, rd);
		if (rd[9:0] !== capacity_cfg) begin
			$error("bin_capacity readback: expected %0d, actual %0d", capacity_cfg, rd[9:0]);
			mismatches++;
		end
	endtask

	task automatic check_field(string name, int want, int got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Result side backpressure.
	always @(negedge clk)
		m_tready <= !idle_on || ($urandom_range(99) >= 23);

	// Compares each result transaction with the oldest expected placement.
	always @(posedge clk) begin : result_check
		placement_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (placements_due.size() == 0) begin
				$error("result with no box pending: tdata %h tuser %0d", m_tdata, m_tuser);
				mismatches++;
			end else begin
				want = placements_due.pop_front();
				check_field("layer_index", int'(want.layer), int'(m_tdata[5:0]));
				check_field("opened_new", int'(want.opened), int'(m_tdata[6]));
				check_field("width_left", int'(want.room_left), int'(m_tdata[16:7]));
				check_field("layer_length", int'(want.length), int'(m_tdata[26:17]));
				check_field("layer_height", int'(want.height), int'(m_tdata[36:27]));
				check_field("status", int'(want.status), int'(m_tuser));
			end
		end
	end

	// Width picks that favor fitting boxes but also reach past the capacity.
	function automatic int pick_width(int cap);
		int r;
		r = $urandom_range(99);
		if (r < 8 && cap < DIM_MAX)
			return $urandom_range(DIM_MAX, cap + 1);
		else if (r < 12)
			return 0;
		else if (r < 16)
			return cap;
		return $urandom_range(cap, 0);
	endfunction

	// Sends random sets of boxes, each closed by a last box; long sets can fill the table.
	task automatic run_sets(int count);
		int sent;
		int set_len;
		int r;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(99);
			if (r < 10)
				set_len = 1;
			else if (r < 75)
				set_len = $urandom_range(40, 2);
			else
				set_len = $urandom_range(90, 41);
			if (set_len > count - sent)
				set_len = count - sent;
			for (int k = 0; k < set_len; k++) begin
				send_box(mk_box(pick_width(int'(capacity_cfg)), $urandom_range(DIM_MAX),
				                $urandom_range(DIM_MAX), k == set_len - 1));
			end
			sent += set_len;
		end
	endtask

	// Best-fit choices, ties, too-wide boxes and clearing at the reset capacity.
	task automatic test_directed_fit();
		send_box(mk_box(50, DIM_MAX, DIM_MAX, 0));
		send_box(mk_box(0, 0, 0, 0));
		send_box(mk_box(51, 7, 7, 0));
		send_box(mk_box(DIM_MAX, DIM_MAX, DIM_MAX, 0));
		send_box(mk_box(20, 5, 7, 0));
		send_box(mk_box(20, 9, 3, 0));
		send_box(mk_box(30, 11, 2, 0));
		send_box(mk_box(10, 12, 9, 0));
		send_box(mk_box(15, 13, 1, 0));
		send_box(mk_box(45, 14, 4, 0));
		// Two layers now hold the same remaining width; the lower one should win.
		send_box(mk_box(5, 15, 600, 0));
		send_box(mk_box(0, 16, 0, 0));
		// A too-wide last box still clears the table.
		send_box(mk_box(60, 17, 5, 1));
		send_box(mk_box(1, 18, 341, 0));
		send_box(mk_box(1, 19, 682, 1));
	endtask

	// Fills every layer, then checks the full status and the clear that follows.
	task automatic test_table_full();
		write_reg(ADDR_CAPACITY, 32'd1);
		for (int k = 0; k < LAYERS; k++)
			send_box(mk_box(1, $urandom_range(DIM_MAX), $urandom_range(DIM_MAX), 0));
		send_box(mk_box(1, 3, 3, 0));
		send_box(mk_box(0, 4, 900, 0));
		send_box(mk_box(2, 5, 5, 0));
		send_box(mk_box(1, 6, 6, 1));
		send_box(mk_box(1, 8, 8, 1));
	endtask

	// Zero and maximum capacity, and a write to an unmapped register.
	task automatic test_capacity_edges();
		write_reg(ADDR_CAPACITY, 32'd0);
		send_box(mk_box(0, 1, 2, 0));
		send_box(mk_box(0, 3, 4, 0));
		send_box(mk_box(1, 5, 6, 0));
		send_box(mk_box(DIM_MAX, 7, 8, 1));
		write_reg(ADDR_CAPACITY, 32'(DIM_MAX));
		write_reg(ADDR_UNMAPPED, 32'd7);
		send_box(mk_box(DIM_MAX, DIM_MAX, 0, 0));
		send_box(mk_box(DIM_MAX, 0, DIM_MAX, 0));
		send_box(mk_box(0, 1, 2, 0));
		send_box(mk_box(512, 682, 341, 0));
		send_box(mk_box(511, 341, 682, 1));
	endtask

	// Random sets across several capacities; one phase runs with no idling at all.
	task automatic test_random_sets();
		write_reg(ADDR_CAPACITY, 32'(bfp_pkg::CAP_RESET));
		run_sets(200);
		write_reg(ADDR_CAPACITY, 32'(DIM_MAX));
		idle_on = 1'b0;
		run_sets(200);
		write_reg(ADDR_CAPACITY, 32'd1);
		idle_on = 1'b1;
		run_sets(120);
		write_reg(ADDR_CAPACITY, $urandom_range(DIM_MAX - 1, 2));
		run_sets(120);
		write_reg(ADDR_CAPACITY, $urandom_range(DIM_MAX - 1, 2));
		run_sets(120);
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		test_directed_fit();
		test_table_full();
		test_capacity_edges();
		test_random_sets();
		wait_idle();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#8000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== best_fit_bin_packer_top.f =====
+incdir+hdl
hdl/bfp_pkg.sv
hdl/bfp_layer_mem.sv
hdl/bfp_ctrl.sv
hdl/best_fit_bin_packer_top.sv
test/best_fit_bin_packer_top_tb.sv
